@@ rtl/core/cst_element_stiffness_unit_assert.svh @@
// Assertion macros for the element stiffness unit.
`ifndef CST_ELEMENT_STIFFNESS_UNIT_ASSERT_SVH
`define CST_ELEMENT_STIFFNESS_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define CST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cst assertion failed");

// Checked on every clock edge, reset included.
`define CST_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cst assertion failed");

`endif

@@ rtl/core/cst_pkg.sv @@
`timescale 1ns / 1ps
package cst_pkg;

  localparam int ID_W = 12;
  localparam int COORD_W = 32;
  localparam int IDX_W = ID_W + 1;
  localparam int VAL_W = 32;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DET_W = PROD_W + 1;
  localparam int NODES = 3;
  localparam int GROUPS = 6;
  localparam int NPD = GROUPS * NODES;
  localparam int NPROD = NPD + 2;
  localparam int STEP_W = $clog2(NPROD);
  localparam int PD_IDX_W = $clog2(NPD);
  localparam int LO_W = 32;
  localparam int HI_W = PROD_W - LO_W;
  localparam int NUM_W = PROD_W + DIFF_W;
  localparam int MAG_W = NUM_W;
  localparam int QUO_W = VAL_W + 1;
  localparam int CMP_W = MAG_W + QUO_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_NODES_DEF = 4096;
  localparam int CFG_W = 2;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [CFG_W-1:0] {
    CFG_D_DIAG,
    CFG_D_OFFDIAG,
    CFG_D_SHEAR
  } cfg_reg_t;

  typedef enum logic [2:0] {
    G_BB_DIAG,
    G_BB_OFF,
    G_BB_SH,
    G_CC_DIAG,
    G_CC_OFF,
    G_CC_SH,
    G_DET
  } grp_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef struct packed {
    logic [NODES-1:0][ID_W-1:0]   id;
    logic [NODES-1:0][DIFF_W-1:0] bb;
    logic [NODES-1:0][DIFF_W-1:0] cc;
    logic [NPD-1:0][PROD_W-1:0]   pd;
    logic [DET_W-1:0]             det;
  } elem_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
    logic             degen;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic             neg;
    logic [MAG_W-1:0] top;
    logic [MAG_W-1:0] bot;
  } div_in_t;

  typedef struct packed {
    logic             strobe;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             degen;
    logic             last;
  } res_t;

endpackage

@@ rtl/core/cst_front.sv @@
`timescale 1ns / 1ps
module cst_front #(
  parameter int MAX_NODES = cst_pkg::MAX_NODES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [cst_pkg::ID_W-1:0]             node_a,
  input  logic [cst_pkg::ID_W-1:0]             node_b,
  input  logic [cst_pkg::ID_W-1:0]             node_c,
  input  logic signed [cst_pkg::COORD_W-1:0]   xa,
  input  logic signed [cst_pkg::COORD_W-1:0]   ya,
  input  logic signed [cst_pkg::COORD_W-1:0]   xb,
  input  logic signed [cst_pkg::COORD_W-1:0]   yb,
  input  logic signed [cst_pkg::COORD_W-1:0]   xc,
  input  logic signed [cst_pkg::COORD_W-1:0]   yc,
  input  logic signed [cst_pkg::COORD_W-1:0]   d_diag,
  input  logic signed [cst_pkg::COORD_W-1:0]   d_offdiag,
  input  logic signed [cst_pkg::COORD_W-1:0]   d_shear,
  output logic                                 push_valid,
  output cst_pkg::elem_t                       push_data,
  input  logic                                 push_ready
);

  localparam int ID_W = cst_pkg::ID_W;
  localparam int DIFF_W = cst_pkg::DIFF_W;
  localparam int PROD_W = cst_pkg::PROD_W;
  localparam int STEP_W = cst_pkg::STEP_W;

  cst_pkg::front_state_t state, state_next;
  cst_pkg::grp_t grp;
  logic [1:0] node;
  logic [STEP_W-1:0] step;
  logic [ID_W-1:0] id_r [cst_pkg::NODES];
  logic signed [DIFF_W-1:0] bb_r [cst_pkg::NODES];
  logic signed [DIFF_W-1:0] cc_r [cst_pkg::NODES];
  logic signed [DIFF_W-1:0] dx2, dy1;
  logic [PROD_W-1:0] pd_r [cst_pkg::NPROD];
  logic signed [DIFF_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic accept, mul_last;

  function automatic logic [ID_W-1:0] sat_id(input logic [ID_W-1:0] v);
    logic [ID_W-1:0] r;
    if (int'(v) >= MAX_NODES) r = ID_W'(MAX_NODES - 1);
    else r = v;
    return r;
  endfunction

  function automatic logic signed [DIFF_W-1:0] diff(input logic signed [cst_pkg::COORD_W-1:0] p,
                                                   input logic signed [cst_pkg::COORD_W-1:0] q);
    return DIFF_W'(p) - DIFF_W'(q);
  endfunction

  assign mul_last = (grp == cst_pkg::G_DET) && (node == 2'd1);
  assign accept = start && !busy;

  always_comb begin
    op_a = bb_r[node];
    op_b = DIFF_W'(d_shear);
    case (grp)
      cst_pkg::G_DET: begin
        op_a = (node == 2'd0) ? cc_r[2] : dx2;
        op_b = (node == 2'd0) ? bb_r[1] : dy1;
      end
      default: begin
        if (grp inside {cst_pkg::G_CC_DIAG, cst_pkg::G_CC_OFF, cst_pkg::G_CC_SH}) begin
          op_a = cc_r[node];
        end
        if (grp inside {cst_pkg::G_BB_DIAG, cst_pkg::G_CC_DIAG}) begin
          op_b = DIFF_W'(d_diag);
        end else if (grp inside {cst_pkg::G_BB_OFF, cst_pkg::G_CC_OFF}) begin
          op_b = DIFF_W'(d_offdiag);
        end
      end
    endcase
  end

  assign prod = op_a * op_b;

  always_comb begin
    state_next = state;
    busy = 1'b1;
    push_valid = 1'b0;
    case (state)
      cst_pkg::F_IDLE: begin
        busy = 1'b0;
        if (start) state_next = cst_pkg::F_MUL;
      end
      cst_pkg::F_MUL: begin
        if (mul_last) state_next = cst_pkg::F_PUSH;
      end
      cst_pkg::F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          busy = 1'b0;
          state_next = start ? cst_pkg::F_MUL : cst_pkg::F_IDLE;
        end
      end
      default: state_next = cst_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cst_pkg::F_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_r[0] <= sat_id(node_a);
      id_r[1] <= sat_id(node_b);
      id_r[2] <= sat_id(node_c);
      bb_r[0] <= diff(yb, yc);
      bb_r[1] <= diff(yc, ya);
      bb_r[2] <= diff(ya, yb);
      cc_r[0] <= diff(xc, xb);
      cc_r[1] <= diff(xa, xc);
      cc_r[2] <= diff(xb, xa);
      dx2 <= diff(xc, xa);
      dy1 <= diff(yb, ya);
      grp <= cst_pkg::G_BB_DIAG;
      node <= 2'd0;
      step <= '0;
    end else if (state == cst_pkg::F_MUL) begin
      pd_r[step] <= prod;
      step <= step + STEP_W'(1);
      if (node == 2'd2 || grp == cst_pkg::G_DET && node == 2'd1) begin
        node <= 2'd0;
        grp <= cst_pkg::grp_t'(grp + 3'd1);
      end else begin
        node <= node + 2'd1;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < cst_pkg::NODES; k++) begin
      push_data.id[k] = id_r[k];
      push_data.bb[k] = bb_r[k];
      push_data.cc[k] = cc_r[k];
    end
    for (int k = 0; k < cst_pkg::NPD; k++) begin
      push_data.pd[k] = pd_r[k];
    end
    push_data.det = {pd_r[cst_pkg::NPD][PROD_W-1], pd_r[cst_pkg::NPD]}
                  - {pd_r[cst_pkg::NPD+1][PROD_W-1], pd_r[cst_pkg::NPD+1]};
  end

endmodule

@@ rtl/core/cst_queue.sv @@
`timescale 1ns / 1ps
module cst_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  cst_pkg::elem_t push_data,
  output logic           push_ready,
  input  logic           pop,
  output logic           head_valid,
  output cst_pkg::elem_t head_data
);

  localparam int DEPTH = cst_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cst_pkg::elem_t entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push, do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign do_push = push_valid && push_ready;
  assign do_pop = pop && head_valid;
  assign head_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule

@@ rtl/core/cst_back.sv @@
`timescale 1ns / 1ps
module cst_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  cst_pkg::elem_t   head_data,
  output logic             pop,
  output cst_pkg::div_in_t div_in
);

  localparam int DIFF_W = cst_pkg::DIFF_W;
  localparam int PROD_W = cst_pkg::PROD_W;
  localparam int LO_W = cst_pkg::LO_W;
  localparam int HI_W = cst_pkg::HI_W;
  localparam int NUM_W = cst_pkg::NUM_W;
  localparam int MAG_W = cst_pkg::MAG_W;
  localparam int DET_W = cst_pkg::DET_W;
  localparam int PD_IDX_W = cst_pkg::PD_IDX_W;
  localparam int PH_W = HI_W + DIFF_W;
  localparam int PL_W = LO_W + 1 + DIFF_W;

  logic [1:0] ci, cj, cs;
  logic [PROD_W-1:0] a0, a1;
  logic signed [DIFF_W-1:0] q0, q1;
  logic signed [PH_W-1:0] ph0_c, ph1_c;
  logic signed [PL_W-1:0] pl0_c, pl1_c;
  logic seq_last;
  cst_pkg::meta_t meta0;

  logic signed [PH_W-1:0] ph0, ph1;
  logic signed [PL_W-1:0] pl0, pl1;
  logic signed [DET_W-1:0] det1, det2;
  cst_pkg::meta_t meta1, meta2, meta2_d;
  logic signed [NUM_W-1:0] num2;
  logic [MAG_W-1:0] an, ad;

  function automatic logic [PD_IDX_W-1:0] pd_idx(input cst_pkg::grp_t g, input logic [1:0] n);
    return PD_IDX_W'(cst_pkg::NODES * int'(g)) + PD_IDX_W'(n);
  endfunction

  assign seq_last = (ci == 2'd2) && (cj == 2'd2) && (cs == 2'd3);
  assign pop = head_valid && seq_last;

  always_comb begin
    a0 = head_data.pd[pd_idx(cst_pkg::G_BB_DIAG, ci)];
    q0 = head_data.bb[cj];
    a1 = head_data.pd[pd_idx(cst_pkg::G_CC_SH, ci)];
    q1 = head_data.cc[cj];
    case (cs)
      2'd0: begin
        a0 = head_data.pd[pd_idx(cst_pkg::G_BB_DIAG, ci)];
        q0 = head_data.bb[cj];
        a1 = head_data.pd[pd_idx(cst_pkg::G_CC_SH, ci)];
        q1 = head_data.cc[cj];
      end
      2'd1: begin
        a0 = head_data.pd[pd_idx(cst_pkg::G_BB_OFF, ci)];
        q0 = head_data.cc[cj];
        a1 = head_data.pd[pd_idx(cst_pkg::G_CC_SH, ci)];
        q1 = head_data.bb[cj];
      end
      2'd2: begin
        a0 = head_data.pd[pd_idx(cst_pkg::G_CC_OFF, ci)];
        q0 = head_data.bb[cj];
        a1 = head_data.pd[pd_idx(cst_pkg::G_BB_SH, ci)];
        q1 = head_data.cc[cj];
      end
      default: begin
        a0 = head_data.pd[pd_idx(cst_pkg::G_CC_DIAG, ci)];
        q0 = head_data.cc[cj];
        a1 = head_data.pd[pd_idx(cst_pkg::G_BB_SH, ci)];
        q1 = head_data.bb[cj];
      end
    endcase
  end

  assign ph0_c = $signed(a0[PROD_W-1:LO_W]) * q0;
  assign ph1_c = $signed(a1[PROD_W-1:LO_W]) * q1;
  assign pl0_c = $signed({1'b0, a0[LO_W-1:0]}) * q0;
  assign pl1_c = $signed({1'b0, a1[LO_W-1:0]}) * q1;

  always_comb begin
    meta0.valid = head_valid;
    meta0.row = {head_data.id[ci], cs[1]};
    meta0.col = {head_data.id[cj], cs[0]};
    meta0.last = seq_last;
    meta0.degen = 1'b0;
  end

  always_comb begin
    meta2_d = meta2;
    meta2_d.degen = det2 == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ci <= 2'd0;
      cj <= 2'd0;
      cs <= 2'd0;
    end else if (head_valid) begin
      cs <= cs + 2'd1;
      if (cs == 2'd3) begin
        if (cj == 2'd2) begin
          cj <= 2'd0;
          ci <= (ci == 2'd2) ? 2'd0 : ci + 2'd1;
        end else begin
          cj <= cj + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ph0 <= ph0_c;
    ph1 <= ph1_c;
    pl0 <= pl0_c;
    pl1 <= pl1_c;
    det1 <= head_data.det;
    num2 <= (NUM_W'(ph0) <<< LO_W) + NUM_W'(pl0) + (NUM_W'(ph1) <<< LO_W) + NUM_W'(pl1);
    det2 <= det1;
    div_in.neg <= num2[NUM_W-1] ^ det2[DET_W-1];
    div_in.top <= an + ad;
    div_in.bot <= ad << 1;
    if (rst) begin
      meta1 <= '0;
      meta2 <= '0;
      div_in.meta <= '0;
    end else begin
      meta1 <= meta0;
      meta2 <= meta1;
      div_in.meta <= meta2_d;
    end
  end

  assign an = num2[NUM_W-1] ? MAG_W'(-num2) : MAG_W'(num2);
  assign ad = det2[DET_W-1] ? MAG_W'(-det2) : MAG_W'(det2);

endmodule

@@ rtl/core/cst_divider.sv @@
`timescale 1ns / 1ps
module cst_divider (
  input  logic             clk,
  input  logic             rst,
  input  cst_pkg::div_in_t div_in,
  output cst_pkg::res_t    res
);

  localparam int MAG_W = cst_pkg::MAG_W;
  localparam int QUO_W = cst_pkg::QUO_W;
  localparam int CMP_W = cst_pkg::CMP_W;
  localparam int VAL_W = cst_pkg::VAL_W;
  localparam int NST = QUO_W + 1;
  localparam logic [QUO_W-1:0] POS_LIMIT = (QUO_W'(1) << (VAL_W - 1)) - QUO_W'(1);
  localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(1) << (VAL_W - 1);

  logic [MAG_W-1:0] rem_q [NST];
  logic [MAG_W-1:0] bot_q [NST];
  logic [QUO_W-1:0] quo_q [NST];
  logic sat_q [NST];
  logic neg_q [NST];
  cst_pkg::meta_t meta_q [NST];
  logic [CMP_W-1:0] shifted [1:NST-1];
  logic take [1:NST-1];
  logic [QUO_W-1:0] qv;
  logic pos_ovf, neg_ovf;
  logic [VAL_W-1:0] value_c;

  always_comb begin
    for (int s = 1; s < NST; s++) begin
      shifted[s] = CMP_W'(bot_q[s-1]) << (QUO_W - s);
      take[s] = CMP_W'(rem_q[s-1]) >= shifted[s];
    end
  end

  always_ff @(posedge clk) begin
    rem_q[0] <= div_in.top;
    bot_q[0] <= div_in.bot;
    quo_q[0] <= '0;
    sat_q[0] <= CMP_W'(div_in.top) >= (CMP_W'(div_in.bot) << QUO_W);
    neg_q[0] <= div_in.neg;
    for (int s = 1; s < NST; s++) begin
      rem_q[s] <= take[s] ? MAG_W'(CMP_W'(rem_q[s-1]) - shifted[s]) : rem_q[s-1];
      bot_q[s] <= bot_q[s-1];
      quo_q[s] <= quo_q[s-1] | (take[s] ? QUO_W'(1) << (QUO_W - s) : '0);
      sat_q[s] <= sat_q[s-1];
      neg_q[s] <= neg_q[s-1];
    end
    if (rst) begin
      for (int s = 0; s < NST; s++) meta_q[s] <= '0;
    end else begin
      meta_q[0] <= div_in.meta;
      for (int s = 1; s < NST; s++) meta_q[s] <= meta_q[s-1];
    end
  end

  assign qv = quo_q[NST-1];
  assign pos_ovf = sat_q[NST-1] || qv > POS_LIMIT;
  assign neg_ovf = sat_q[NST-1] || qv > NEG_LIMIT;

  always_comb begin
    if (meta_q[NST-1].degen) value_c = '0;
    else if (neg_q[NST-1]) value_c = neg_ovf ? cst_pkg::VAL_MIN : VAL_W'(-qv);
    else value_c = pos_ovf ? cst_pkg::VAL_MAX : qv[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    res.row <= meta_q[NST-1].row;
    res.col <= meta_q[NST-1].col;
    res.value <= value_c;
    res.degen <= meta_q[NST-1].degen;
    if (rst) begin
      res.strobe <= 1'b0;
      res.last <= 1'b0;
    end else begin
      res.last <= meta_q[NST-1].valid && meta_q[NST-1].last;
      res.strobe <= meta_q[NST-1].valid;
    end
  end

endmodule

@@ rtl/core/cst_element_stiffness_unit.sv @@
`timescale 1ns / 1ps
// Constant strain triangle stiffness unit. A triangle is taken when start is
// high and busy is low; it then yields 36 (row, column, value) results, one per
// cycle on consecutive cycles, each marked by strobe for one cycle, with last on
// the 36th. The result side cannot be stalled. The front end forms each
// triangle's products one after another on its one shared 33x33 multiplier
// (18 node-by-D products and two determinant products), then pushes the
// element into a two-entry queue; busy is low again in the push cycle when the
// queue has room, so a new triangle can be taken while earlier triangles are
// still being emitted.
// After acceptance a triangle passes through the front end, a multiply
// stage, a sum stage, an absolute-value stage, a 34-stage restoring divider and
// an output register.
module cst_element_stiffness_unit #(
  parameter int MAX_NODES = cst_pkg::MAX_NODES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [cst_pkg::ID_W-1:0]            node_a,
  input  logic [cst_pkg::ID_W-1:0]            node_b,
  input  logic [cst_pkg::ID_W-1:0]            node_c,
  input  logic signed [cst_pkg::COORD_W-1:0]  xa,
  input  logic signed [cst_pkg::COORD_W-1:0]  ya,
  input  logic signed [cst_pkg::COORD_W-1:0]  xb,
  input  logic signed [cst_pkg::COORD_W-1:0]  yb,
  input  logic signed [cst_pkg::COORD_W-1:0]  xc,
  input  logic signed [cst_pkg::COORD_W-1:0]  yc,
  input  logic                                cfg_write,
  input  logic [cst_pkg::CFG_W-1:0]           cfg_index,
  input  logic signed [cst_pkg::COORD_W-1:0]  cfg_data,
  output logic                                strobe,
  output logic [cst_pkg::IDX_W-1:0]           row_index,
  output logic [cst_pkg::IDX_W-1:0]           col_index,
  output logic signed [cst_pkg::VAL_W-1:0]    value,
  output logic                                degenerate,
  output logic                                last
);

  logic signed [cst_pkg::COORD_W-1:0] d_diag, d_offdiag, d_shear;
  logic push_valid, push_ready, head_valid, pop;
  cst_pkg::elem_t push_data, head_data;
  cst_pkg::div_in_t div_in;
  cst_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_diag <= '0;
      d_offdiag <= '0;
      d_shear <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        cst_pkg::CFG_D_DIAG: d_diag <= cfg_data;
        cst_pkg::CFG_D_OFFDIAG: d_offdiag <= cfg_data;
        cst_pkg::CFG_D_SHEAR: d_shear <= cfg_data;
        default: ;
      endcase
    end
  end

  cst_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .node_a(node_a),
    .node_b(node_b),
    .node_c(node_c),
    .xa(xa),
    .ya(ya),
    .xb(xb),
    .yb(yb),
    .xc(xc),
    .yc(yc),
    .d_diag(d_diag),
    .d_offdiag(d_offdiag),
    .d_shear(d_shear),
    .push_valid(push_valid),
    .push_data(push_data),
    .push_ready(push_ready)
  );

  cst_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(push_valid),
    .push_data(push_data),
    .push_ready(push_ready),
    .pop(pop),
    .head_valid(head_valid),
    .head_data(head_data)
  );

  cst_back u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(head_valid),
    .head_data(head_data),
    .pop(pop),
    .div_in(div_in)
  );

  cst_divider u_divider (
    .clk(clk),
    .rst(rst),
    .div_in(div_in),
    .res(res)
  );

  assign strobe = res.strobe;
  assign row_index = res.row;
  assign col_index = res.col;
  assign value = res.value;
  assign degenerate = res.degen;
  assign last = res.last;

endmodule

@@ rtl/core/cst_checker.sv @@
`timescale 1ns / 1ps
`include "cst_element_stiffness_unit_assert.svh"
module cst_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             strobe,
  input logic signed [cst_pkg::VAL_W-1:0] value,
  input logic                             degenerate,
  input logic                             last
);

  `CST_ASSERT(a_last_has_strobe, last |-> strobe)
  `CST_ASSERT(a_degenerate_zero, strobe && degenerate |-> value == '0)
  `CST_ASSERT(a_burst_unbroken, strobe && !last |=> strobe)
  `CST_ASSERT_ALWAYS(a_reset_quiet, rst |=> !strobe)

endmodule

bind cst_element_stiffness_unit cst_checker u_checker (
  .clk(clk),
  .rst(rst),
  .strobe(strobe),
  .value(value),
  .degenerate(degenerate),
  .last(last)
);
